@@ sv/wcg_pkg.sv @@
// wcg_pkg: constants, types and weight table for the window coefficient generator.
// Used by wcg_cell, wcg_cos and window_coefficient_generator; depends on nothing.
`default_nettype none

package wcg_pkg;

	localparam int MAX_LENGTH           = 2048;
	localparam int RESULT_BITS          = 8;
	localparam int RESULT_FRACTION_BITS = 7;

	localparam int KIND_BITS   = 3;
	localparam int LEN_BITS    = 12;
	localparam int INDEX_BITS  = 11;
	localparam int DEN_BITS    = $clog2(MAX_LENGTH);
	localparam int NUM_TERMS   = 3;
	localparam int KN_BITS     = INDEX_BITS + 2;
	localparam int PHASE_BITS  = 16;
	localparam int NUM_CELLS   = KN_BITS + PHASE_BITS;
	localparam int COS_STAGES  = 6;
	localparam int SUM_BITS    = 34;
	localparam int SUM_SHIFT   = 30 - RESULT_FRACTION_BITS;

	localparam int ADDR_BITS = 3;
	localparam logic [ADDR_BITS-1:0] ADDR_KIND   = 3'd0;
	localparam logic [ADDR_BITS-1:0] ADDR_LENGTH = 3'd4;

	localparam logic [KIND_BITS-1:0] KIND_RECT    = 3'd0;
	localparam logic [KIND_BITS-1:0] KIND_HANN    = 3'd1;
	localparam logic [KIND_BITS-1:0] KIND_HAMMING = 3'd2;
	localparam logic [KIND_BITS-1:0] KIND_BH3     = 3'd3;
	localparam logic [KIND_BITS-1:0] KIND_BH4     = 3'd4;

	localparam logic [KIND_BITS-1:0] KIND_RESET   = KIND_HAMMING;
	localparam logic [LEN_BITS-1:0]  LENGTH_RESET = LEN_BITS'(MAX_LENGTH);

	// quarter-wave cosine polynomial, Q30
	localparam logic [31:0] COS_A   = 32'd1324675879;
	localparam logic [31:0] COS_B   = 32'd272375560;
	localparam logic [31:0] COS_C   = 32'd22401992;
	localparam logic [31:0] COS_D   = 32'd987049;
	localparam logic [31:0] Q30_ONE = 32'd1073741824;

	localparam logic signed [SUM_BITS-1:0] RES_MAX =
		SUM_BITS'((64'sd1 <<< (RESULT_BITS - 1)) - 64'sd1);
	localparam logic signed [SUM_BITS-1:0] RES_MIN =
		SUM_BITS'(-(64'sd1 <<< (RESULT_BITS - 1)));
	localparam logic signed [SUM_BITS-1:0] TRUNC_BIAS =
		SUM_BITS'((64'sd1 <<< SUM_SHIFT) - 64'sd1);

	typedef struct packed {
		logic [DEN_BITS-1:0]   rem;
		logic [KN_BITS-1:0]    kn;
		logic [PHASE_BITS-1:0] phase;
	} div_lane_t;

	typedef struct packed {
		logic                            valid;
		div_lane_t [NUM_TERMS-1:0]       lane;
	} div_word_t;

	typedef struct packed {
		logic [15:0] a0;
		logic [14:0] a1;
		logic [14:0] a2;
		logic [14:0] a3;
	} weights_t;

	function automatic weights_t kind_weights(input logic [KIND_BITS-1:0] kind);
		weights_t w;
		case (kind)
			KIND_HANN:    w = '{16'd16384, 15'd16384, 15'd0,    15'd0};
			KIND_HAMMING: w = '{16'd17695, 15'd15073, 15'd0,    15'd0};
			KIND_BH3:     w = '{16'd13868, 15'd16304, 15'd2596, 15'd0};
			KIND_BH4:     w = '{16'd11756, 15'd16000, 15'd4629, 15'd383};
			default:      w = '{16'd32768, 15'd0,     15'd0,    15'd0};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

@@ sv/wcg_cell.sv @@
// wcg_cell: one restoring-division step for all three phase lanes.
// Depends on wcg_pkg.
`default_nettype none

module wcg_cell (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               en,
	input  wire  [wcg_pkg::DEN_BITS-1:0]      den,
	input  wire  [wcg_pkg::NUM_TERMS-1:0]     dbit,
	input  wcg_pkg::div_word_t                in_word,
	output wcg_pkg::div_word_t                out_word
);
	import wcg_pkg::*;

	logic                      valid_q;
	div_lane_t [NUM_TERMS-1:0] lane_q;
	div_lane_t [NUM_TERMS-1:0] lane_d;

	always_comb begin
		for (int l = 0; l < NUM_TERMS; l++) begin
			logic [DEN_BITS:0] rs;
			logic              qb;
			rs = {in_word.lane[l].rem, dbit[l]};
			qb = (rs >= {1'b0, den});
			lane_d[l].kn    = in_word.lane[l].kn;
			lane_d[l].rem   = qb ? DEN_BITS'(rs - {1'b0, den}) : DEN_BITS'(rs);
			lane_d[l].phase = {in_word.lane[l].phase[PHASE_BITS-2:0], qb};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_word.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q <= lane_d;
		end
	end

	assign out_word = {valid_q, lane_q};

`ifndef SYNTH
	a_adv_valid: assert property (@(posedge clk) disable iff (!arst_n)
		en && in_word.valid |=> valid_q)
		else $error("cell dropped a word");
	a_adv_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		en && !in_word.valid |=> !valid_q)
		else $error("cell invented a word");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en && valid_q |=> valid_q && $stable(lane_q))
		else $error("cell word changed during stall");
`endif

endmodule

`default_nettype wire

@@ sv/wcg_cos.sv @@
// wcg_cos: six-stage Q1.15 cosine of a 16-bit phase (quadrant fold + Horner).
// Depends on wcg_pkg.
`default_nettype none

module wcg_cos (
	input  wire                              clk,
	input  wire                              en,
	input  wire  [wcg_pkg::PHASE_BITS-1:0]   phase,
	output logic signed [15:0]               cos_val
);
	import wcg_pkg::*;

	logic [1:0]  quad;
	logic [14:0] y;
	logic [15:0] u;
	logic [31:0] uu;
	logic [62:0] p2, p3, p4, p5;
	logic [31:0] tc, rsum;
	logic [16:0] m;
	logic [14:0] mag;

	logic [30:0] v_s1, v_s2, v_s3, v_s4;
	logic        neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [31:0] t_s2, t_s3, t_s4;
	logic signed [32:0] t_s5;

	assign quad = phase[15:14];
	assign y    = quad[0] ? 15'(15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
	assign u    = {y, 1'b0};
	assign uu   = 32'(u) * 32'(u);

	assign p2 = 63'(COS_D) * 63'(v_s1);
	assign p3 = 63'(t_s2) * 63'(v_s2);
	assign p4 = 63'(t_s3) * 63'(v_s3);
	assign p5 = 63'(t_s4) * 63'(v_s4);

	assign tc   = t_s5[32] ? 32'd0 : t_s5[31:0];
	assign rsum = tc + 32'd16384;
	assign m    = rsum[31:15];
	assign mag  = (m > 17'd32767) ? 15'h7fff : m[14:0];

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1   <= uu[30:0];
			neg_s1 <= (quad == 2'd1) || (quad == 2'd2);
			t_s2   <= COS_C - p2[61:30];
			v_s2   <= v_s1;
			neg_s2 <= neg_s1;
			t_s3   <= COS_B - p3[61:30];
			v_s3   <= v_s2;
			neg_s3 <= neg_s2;
			t_s4   <= COS_A - p4[61:30];
			v_s4   <= v_s3;
			neg_s4 <= neg_s3;
			t_s5   <= $signed({1'b0, Q30_ONE}) - $signed({1'b0, p5[61:30]});
			neg_s5 <= neg_s4;
			cos_val <= neg_s5 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

endmodule

`default_nettype wire

@@ sv/window_coefficient_generator.sv @@
// window_coefficient_generator: window coefficient w(n) for rectangular, Hann,
// Hamming and 3/4-term Blackman-Harris windows. Depends on wcg_pkg, wcg_cell, wcg_cos.
//
// Usage:
//  - Configure window_kind (addr 0) and window_length (addr 4) over the APB port
//    while no word is in flight; prdata reads them back, pready is always high.
//  - Sample words enter on sample_valid/sample_ready with sample_index; one
//    coefficient word leaves on coef_valid/coef_ready per sample, in order.
//  - Stages in order: input register, 29 division cells (one quotient bit
//    each, three phase lanes side by side), 6 cosine stages, weight product
//    stage and the output register. Throughput is one word per cycle while the output is not stalled.
//  - The whole pipeline advances together; while coef_valid is high and
//    coef_ready low it holds and sample_ready is low.
//  - Reset clears all valid flags and loads kind Hamming, length 2048.
`default_nettype none

module window_coefficient_generator (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  psel,
	input  wire                                  penable,
	input  wire                                  pwrite,
	input  wire  [wcg_pkg::ADDR_BITS-1:0]        paddr,
	input  wire  [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	input  wire                                  sample_valid,
	output logic                                 sample_ready,
	input  wire  [wcg_pkg::INDEX_BITS-1:0]       sample_index,
	output logic                                 coef_valid,
	input  wire                                  coef_ready,
	output logic signed [wcg_pkg::RESULT_BITS-1:0] coefficient
);
	import wcg_pkg::*;

	logic [KIND_BITS-1:0] kind_q;
	logic [LEN_BITS-1:0]  len_q;
	logic [LEN_BITS-1:0]  len_c;
	logic [DEN_BITS-1:0]  den;
	logic                 en;
	logic                 wr;

	logic                      s0_valid_q;
	div_lane_t [NUM_TERMS-1:0] s0_lane_q;
	div_word_t cell_w [NUM_CELLS+1];

	logic signed [15:0]   cos_v [NUM_TERMS];
	logic [COS_STAGES-1:0] cos_vld_q;

	weights_t             w;
	logic                 prod_vld_q;
	logic signed [SUM_BITS-1:0] base_p;
	logic signed [31:0]   prod_p [NUM_TERMS];
	logic signed [SUM_BITS-1:0] s, sb, r;
	logic                 coef_valid_q;
	logic signed [RESULT_BITS-1:0] coef_q;

	// configuration
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_RESET;
			len_q  <= LENGTH_RESET;
		end else if (wr) begin
			if (paddr == ADDR_KIND)
				kind_q <= pwdata[KIND_BITS-1:0];
			if (paddr == ADDR_LENGTH)
				len_q <= pwdata[LEN_BITS-1:0];
		end
	end

	always_comb begin
		case (paddr)
			ADDR_KIND:   prdata = 32'(kind_q);
			ADDR_LENGTH: prdata = 32'(len_q);
			default:     prdata = 32'd0;
		endcase
	end

	always_comb begin
		if (len_q < LEN_BITS'(2))
			len_c = LEN_BITS'(2);
		else if (len_q > LEN_BITS'(MAX_LENGTH))
			len_c = LEN_BITS'(MAX_LENGTH);
		else
			len_c = len_q;
	end
	assign den = DEN_BITS'(len_c - LEN_BITS'(1));

	// pipeline control
	assign en           = !coef_valid_q || coef_ready;
	assign sample_ready = en;

	// input register: k*n for k = 1..3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s0_valid_q <= 1'b0;
		end else if (en) begin
			s0_valid_q <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NUM_TERMS; l++) begin
				s0_lane_q[l].kn    <= KN_BITS'(KN_BITS'(sample_index) * KN_BITS'(l + 1));
				s0_lane_q[l].rem   <= '0;
				s0_lane_q[l].phase <= '0;
			end
		end
	end

	assign cell_w[0] = {s0_valid_q, s0_lane_q};

	// division chain: phase = floor(k*n*2^16 / den) mod 2^16
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		logic [NUM_TERMS-1:0] dbit;
		for (genvar l = 0; l < NUM_TERMS; l++) begin : g_bit
			if (i < KN_BITS) begin : g_num
				assign dbit[l] = cell_w[i].lane[l].kn[KN_BITS-1-i];
			end else begin : g_frac
				assign dbit[l] = 1'b0;
			end
		end
		wcg_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.den      (den),
			.dbit     (dbit),
			.in_word  (cell_w[i]),
			.out_word (cell_w[i+1])
		);
	end

	// cosine lanes
	for (genvar l = 0; l < NUM_TERMS; l++) begin : g_cos
		wcg_cos u_cos (
			.clk     (clk),
			.en      (en),
			.phase   (cell_w[NUM_CELLS].lane[l].phase),
			.cos_val (cos_v[l])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_vld_q    <= '0;
			prod_vld_q   <= 1'b0;
			coef_valid_q <= 1'b0;
		end else if (en) begin
			cos_vld_q    <= {cos_vld_q[COS_STAGES-2:0], cell_w[NUM_CELLS].valid};
			prod_vld_q   <= cos_vld_q[COS_STAGES-1];
			coef_valid_q <= prod_vld_q;
		end
	end

	// weighting
	assign w = kind_weights(kind_q);

	always_ff @(posedge clk) begin
		if (en) begin
			base_p    <= $signed(SUM_BITS'({w.a0, 15'd0}));
			prod_p[0] <= $signed({1'b0, w.a1}) * cos_v[0];
			prod_p[1] <= $signed({1'b0, w.a2}) * cos_v[1];
			prod_p[2] <= $signed({1'b0, w.a3}) * cos_v[2];
		end
	end

	always_comb begin
		s  = base_p - SUM_BITS'(prod_p[0]) + SUM_BITS'(prod_p[1]) - SUM_BITS'(prod_p[2]);
		sb = s[SUM_BITS-1] ? s + TRUNC_BIAS : s;
		r  = sb >>> SUM_SHIFT;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (r > RES_MAX)
				coef_q <= RES_MAX[RESULT_BITS-1:0];
			else if (r < RES_MIN)
				coef_q <= RES_MIN[RESULT_BITS-1:0];
			else
				coef_q <= r[RESULT_BITS-1:0];
		end
	end

	assign coef_valid  = coef_valid_q;
	assign coefficient = coef_q;

endmodule

`default_nettype wire
